/* sv/sdlq_pkg.sv */
package sdlq_pkg;

  localparam int THREAD_COUNT_DEF = 16;
  localparam int KEY_W = 32;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_PRIO_INSERT  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_DELTA_INSERT = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_DEQUEUE      = CMD_W'(2);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start;
    logic walk_step;
    logic link;
    logic dequeue;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic is_dequeue;
    logic walk_go;
  } dp_status_t;

endpackage

/* sv/sdlq_ifs.sv */
interface sdlq_in_if #(
  parameter int TID_W = $clog2(sdlq_pkg::THREAD_COUNT_DEF)
) ();
  logic                        valid;
  logic                        ready;
  logic [sdlq_pkg::CMD_W-1:0]  cmd;
  logic                        list_select;
  logic [TID_W-1:0]            thread_id;
  logic [sdlq_pkg::KEY_W-1:0]  key_value;

  modport source (output valid, cmd, list_select, thread_id, key_value, input ready);
  modport sink (input valid, cmd, list_select, thread_id, key_value, output ready);
  modport monitor (input valid, ready, cmd, list_select, thread_id, key_value);
endinterface

interface sdlq_out_if #(
  parameter int HEAD_W = $clog2(sdlq_pkg::THREAD_COUNT_DEF + 1)
) ();
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] head_thread;
  logic              was_empty;

  modport source (output valid, head_thread, was_empty, input ready);
  modport sink (input valid, head_thread, was_empty, output ready);
  modport monitor (input valid, ready, head_thread, was_empty);
endinterface

/* sv/sorted_and_delta_list_queue_unit.sv */
// Sorted and delta list queue: a ready list ordered by priority and a sleep
// list of tick deltas, sharing one node table with a node per thread. Each
// transaction on request yields exactly one transaction on response. A
// dequeue passes through the start and dequeue steps; an insert walks the
// list, passing at most THREAD_COUNT + 2 nodes, and then links. The walk
// visits one linked node per cycle through the node table's single read path.
// An unused command or an ignored insert goes from the start step straight to
// the done step. A result waits in the done step while a previous result
// still waits in the output register. One request is processed at a time;
// the next is accepted once the controller is back in idle, which it reaches
// as a result enters the output register, even while that result still waits.
module sorted_and_delta_list_queue_unit #(
  parameter int THREAD_COUNT = sdlq_pkg::THREAD_COUNT_DEF
) (
  input logic         clk,
  input logic         rst,
  sdlq_in_if.sink     request,
  sdlq_out_if.source  response
);

  localparam int TID_W = $clog2(THREAD_COUNT);
  localparam int HEAD_W = $clog2(THREAD_COUNT + 1);

  sdlq_pkg::dp_cmd_t    cmd;
  sdlq_pkg::dp_status_t status;

  sdlq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdlq_dp #(
    .THREAD_COUNT (THREAD_COUNT),
    .TID_W        (TID_W),
    .HEAD_W       (HEAD_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_cmd         (request.cmd),
    .in_list_select (request.list_select),
    .in_thread_id   (request.thread_id),
    .in_key_value   (request.key_value),
    .head_thread    (response.head_thread),
    .was_empty      (response.was_empty)
  );

endmodule

/* sv/sdlq_ctrl.sv */
module sdlq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sdlq_pkg::dp_status_t status,
  output sdlq_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_WALK  = 6'b000100,
    S_LINK  = 6'b001000,
    S_DEQ   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        // The root's successor is loaded for both walks and dequeues.
        cmd.start = 1'b1;
        if (status.is_insert) begin
          state_next = S_WALK;
        end else if (status.is_dequeue) begin
          state_next = S_DEQ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (status.walk_go) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link = 1'b1;
        state_next = S_DONE;
      end
      S_DEQ: begin
        cmd.dequeue = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= cmd.load_out ? 1'b1 : (out_valid && !out_ready);
    end
  end

endmodule

/* sv/sdlq_dp.sv */
module sdlq_dp #(
  parameter int THREAD_COUNT = sdlq_pkg::THREAD_COUNT_DEF,
  parameter int TID_W = $clog2(THREAD_COUNT),
  parameter int HEAD_W = $clog2(THREAD_COUNT + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sdlq_pkg::dp_cmd_t          cmd,
  output sdlq_pkg::dp_status_t       status,
  input  logic [sdlq_pkg::CMD_W-1:0] in_cmd,
  input  logic                       in_list_select,
  input  logic [TID_W-1:0]           in_thread_id,
  input  logic [sdlq_pkg::KEY_W-1:0] in_key_value,
  output logic [HEAD_W-1:0]          head_thread,
  output logic                       was_empty
);

  localparam int NODE_COUNT = THREAD_COUNT + 2;
  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int STEP_W = $clog2(NODE_COUNT + 1);
  localparam logic [IDX_W-1:0] READY_ROOT = IDX_W'(THREAD_COUNT + 0);
  localparam logic [IDX_W-1:0] SLEEP_ROOT = IDX_W'(THREAD_COUNT + 1);

  logic [IDX_W-1:0]           next_link [NODE_COUNT];
  logic [IDX_W-1:0]           prev_link [NODE_COUNT];
  logic [sdlq_pkg::KEY_W-1:0] node_key  [NODE_COUNT];

  logic [sdlq_pkg::CMD_W-1:0] op;
  logic [IDX_W-1:0]           root;
  logic [TID_W-1:0]           tid;
  logic [sdlq_pkg::KEY_W-1:0] key;
  logic [IDX_W-1:0]           stop;
  logic [STEP_W-1:0]          steps;
  logic [HEAD_W-1:0]          res_head;
  logic                       res_empty;

  logic [IDX_W-1:0]           nl_addr;
  logic [IDX_W-1:0]           nl_rd;
  logic [IDX_W-1:0]           prior_node;
  logic [IDX_W-1:0]           tid_idx;
  logic [sdlq_pkg::KEY_W-1:0] key_at_stop;
  logic                       tid_ok;
  logic                       is_delta;
  logic                       stop_is_root;

  // Each table is read at one address per cycle.
  assign nl_addr     = cmd.start ? root : stop;
  assign nl_rd       = next_link[nl_addr];
  assign prior_node  = prev_link[stop];
  assign key_at_stop = node_key[stop];
  assign tid_idx     = IDX_W'(tid);

  assign tid_ok       = {1'b0, tid} < (TID_W + 1)'(THREAD_COUNT);
  assign is_delta     = (op == sdlq_pkg::CMD_DELTA_INSERT);
  assign stop_is_root = (stop == root);

  assign status.is_insert    = ((op == sdlq_pkg::CMD_PRIO_INSERT) || is_delta) && tid_ok;
  assign status.is_dequeue   = (op == sdlq_pkg::CMD_DEQUEUE);
  assign status.walk_go      = !stop_is_root && (steps < STEP_W'(NODE_COUNT)) &&
                               (key_at_stop <= key);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= in_cmd;
      root <= in_list_select ? SLEEP_ROOT : READY_ROOT;
      tid <= in_thread_id;
      key <= in_key_value;
      res_head <= HEAD_W'(THREAD_COUNT);
      res_empty <= 1'b0;
    end
    if (cmd.start) begin
      stop <= nl_rd;
      steps <= '0;
    end
    if (cmd.walk_step) begin
      if (is_delta) begin
        key <= key - key_at_stop;
      end
      stop <= nl_rd;
      steps <= steps + 1'b1;
    end
    if (cmd.dequeue) begin
      if (stop_is_root) begin
        res_empty <= 1'b1;
      end else begin
        res_head <= stop[HEAD_W-1:0];
      end
    end
    if (cmd.link) begin
      // The successor's delta shrinks by the remainder; the node's own key is
      // written last so that it wins if the two addresses coincide.
      if (is_delta && !stop_is_root) begin
        node_key[stop] <= key_at_stop - key;
      end
      node_key[tid_idx] <= key;
    end
    if (cmd.load_out) begin
      head_thread <= res_head;
      was_empty <= res_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        next_link[i] <= (i >= THREAD_COUNT) ? IDX_W'(i) : '0;
        prev_link[i] <= (i >= THREAD_COUNT) ? IDX_W'(i) : '0;
      end
    end else if (cmd.link) begin
      next_link[prior_node] <= tid_idx;
      next_link[tid_idx] <= stop;
      prev_link[tid_idx] <= prior_node;
      prev_link[stop] <= tid_idx;
    end else if (cmd.dequeue && !stop_is_root) begin
      // Here stop holds the head and nl_rd its successor.
      next_link[root] <= nl_rd;
      prev_link[nl_rd] <= root;
    end
  end

endmodule

/* sv/sdlq_checker.sv */
module sdlq_checker #(
  parameter int THREAD_COUNT = sdlq_pkg::THREAD_COUNT_DEF,
  parameter int HEAD_W = $clog2(THREAD_COUNT + 1)
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [HEAD_W-1:0] head_thread,
  input logic              was_empty
);

  // An empty list never reports a thread.
  a_empty_no_thread: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_empty |-> head_thread == HEAD_W'(THREAD_COUNT))
    else $error("empty dequeue reported a thread");

  // Requests are processed one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in progress");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(head_thread) && $stable(was_empty))
    else $error("stalled result changed");

endmodule

bind sorted_and_delta_list_queue_unit sdlq_checker #(
  .THREAD_COUNT (THREAD_COUNT),
  .HEAD_W       (HEAD_W)
) u_sdlq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .head_thread (response.head_thread),
  .was_empty   (response.was_empty)
);

/* verif/sdlq_list_mirror.sv */
`timescale 1ns / 100ps

module sdlq_list_mirror (
  input  logic              clk,
  input  logic              rst,
  sdlq_in_if.monitor        request,
  sdlq_out_if.monitor       response,
  output int                mismatch_count,
  output int                awaited_count
);

  import sdlq_pkg::*;

  localparam int THREADS    = THREAD_COUNT_DEF;
  localparam int NODES      = THREADS + 2;
  localparam int READY_ROOT = THREADS;
  localparam int SLEEP_ROOT = THREADS + 1;
  localparam int NODE_W     = $clog2(NODES);
  localparam int TID_W      = $clog2(THREADS);
  localparam int HEAD_W     = $clog2(THREADS + 1);
  localparam int REPORT_CAP = 50;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head_thread;
    logic              was_empty;
  } sched_result_t;

  node_t             next_node [NODES];
  node_t             prev_node [NODES];
  logic [KEY_W-1:0]  node_key  [NODES];

  sched_result_t awaited_heads[$];
  sched_result_t oldest;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < REPORT_CAP)
      $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Applies one request to the mirrored node table and returns the result it must give.
  function automatic sched_result_t next_schedule_result(
    input logic [CMD_W-1:0] op,
    input logic             sel,
    input logic [TID_W-1:0] tid,
    input logic [KEY_W-1:0] kv
  );
    sched_result_t    res;
    node_t            root;
    node_t            stop;
    node_t            prior;
    node_t            head;
    node_t            after;
    int               steps;
    logic [KEY_W-1:0] remain;
    res.head_thread = HEAD_W'(THREADS);
    res.was_empty   = 1'b0;
    root   = sel ? node_t'(SLEEP_ROOT) : node_t'(READY_ROOT);
    remain = kv;
    if (op == CMD_PRIO_INSERT || op == CMD_DELTA_INSERT) begin
      if (int'(tid) < THREADS) begin
        stop  = next_node[root];
        steps = 0;
        // The step bound keeps the walk finite when a list has been corrupted.
        while (stop != root && steps < NODES && node_key[stop] <= remain) begin
          if (op == CMD_DELTA_INSERT)
            remain = remain - node_key[stop];
          stop = next_node[stop];
          steps++;
        end
        prior            = prev_node[stop];
        next_node[prior] = node_t'(tid);
        next_node[tid]   = stop;
        prev_node[tid]   = prior;
        prev_node[stop]  = node_t'(tid);
        if (op == CMD_DELTA_INSERT && stop != root)
          node_key[next_node[tid]] = node_key[next_node[tid]] - remain;
        node_key[tid] = remain;
      end
    end else if (op == CMD_DEQUEUE) begin
      head = next_node[root];
      if (head == root) begin
        res.was_empty = 1'b1;
      end else begin
        after            = next_node[head];
        next_node[root]  = after;
        prev_node[after] = root;
        res.head_thread  = HEAD_W'(head);
      end
    end
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES; n++) begin
        next_node[n] = '0;
        prev_node[n] = '0;
        node_key[n]  = '0;
      end
      next_node[READY_ROOT] = node_t'(READY_ROOT);
      prev_node[READY_ROOT] = node_t'(READY_ROOT);
      next_node[SLEEP_ROOT] = node_t'(SLEEP_ROOT);
      prev_node[SLEEP_ROOT] = node_t'(SLEEP_ROOT);
      awaited_heads.delete();
    end else begin
      // A result can never belong to a request accepted at the same edge, so it is
      // checked before that request is predicted.
      if (response.valid && response.ready) begin
        if (awaited_heads.size() == 0) begin
          report_mismatch("head_thread with no transaction awaited", response.head_thread, -1);
        end else begin
          oldest = awaited_heads.pop_front();
          if (response.head_thread !== oldest.head_thread)
            report_mismatch("head_thread", response.head_thread, oldest.head_thread);
          if (response.was_empty !== oldest.was_empty)
            report_mismatch("was_empty", response.was_empty, oldest.was_empty);
        end
      end
      if (request.valid && request.ready)
        awaited_heads.push_back(next_schedule_result(request.cmd, request.list_select,
                                                     request.thread_id, request.key_value));
    end
    awaited_count = awaited_heads.size();
  end

endmodule

/* verif/tb_sorted_and_delta_list_queue_unit.sv */
`timescale 1ns / 100ps

module tb_sorted_and_delta_list_queue_unit;

  localparam int THREADS        = sdlq_pkg::THREAD_COUNT_DEF;
  localparam int TID_W          = $clog2(THREADS);
  localparam int CMD_W          = sdlq_pkg::CMD_W;
  localparam int KEY_W          = sdlq_pkg::KEY_W;
  localparam int RANDOM_ITEMS   = 1830;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  // The block leaves this command code unused.
  localparam logic [CMD_W-1:0] CMD_RESERVED = CMD_W'(3);

  logic clk;
  logic rst;

  sdlq_in_if  request_ch ();
  sdlq_out_if response_ch ();

  int mismatch_count;
  int awaited_count;
  int idle_cycles;

  int gap_max;
  int burst_left;
  bit long_hold;
  bit rx_eager;
  int rx_cycle;
  logic [7:0] stall_mask;

  // Threads believed to be linked, and the list each one went to.
  bit on_list [THREADS];
  bit home    [THREADS];

  sorted_and_delta_list_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  sdlq_list_mirror mirror (
    .clk            (clk),
    .rst            (rst),
    .request        (request_ch),
    .response       (response_ch),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) ||
        (response_ch.valid && response_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A dequeued thread becomes free for a fresh insert once its result is seen.
  always @(posedge clk) begin
    if (!rst && response_ch.valid && response_ch.ready && !response_ch.was_empty &&
        response_ch.head_thread < THREADS)
      on_list[response_ch.head_thread[TID_W-1:0]] <= 1'b0;
  end

  initial begin
    response_ch.ready = 1'b0;
    stall_mask = 8'hFF;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        response_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end
      if (rx_cycle % 48 == 0)
        stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      response_ch.ready = rx_eager | stall_mask[rx_cycle % 8];
      rx_cycle++;
    end
  end

  task automatic offer(input logic [CMD_W-1:0] op, input logic sel,
                       input logic [TID_W-1:0] tid, input logic [KEY_W-1:0] kv);
    int gap;
    request_ch.cmd         = op;
    request_ch.list_select = sel;
    request_ch.thread_id   = tid;
    request_ch.key_value   = kv;
    request_ch.valid       = 1'b1;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        request_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input bit delta);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return delta ? KEY_W'($urandom_range(0, 60)) : KEY_W'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic random_item(input int insert_pct, input bit allow_relink);
    int roll;
    int free_n;
    int ready_n;
    int sleep_n;
    int pick;
    logic sel;
    logic [CMD_W-1:0] op;
    free_n  = 0;
    ready_n = 0;
    sleep_n = 0;
    for (int t = 0; t < THREADS; t++) begin
      if (!on_list[t]) free_n++;
      else if (home[t]) sleep_n++;
      else ready_n++;
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      offer(CMD_RESERVED, 1'($urandom), TID_W'($urandom), $urandom);
    end else if (roll < 9) begin
      offer(sdlq_pkg::CMD_DEQUEUE, 1'($urandom), TID_W'($urandom), $urandom);
    end else if (allow_relink && roll < 25) begin
      // Inserting a thread that may already be linked corrupts its list on purpose. The
      // thread stays on its home list, so the two lists never share nodes.
      pick = $urandom_range(0, THREADS - 1);
      on_list[pick] = 1'b1;
      op = $urandom_range(0, 1) ? sdlq_pkg::CMD_DELTA_INSERT : sdlq_pkg::CMD_PRIO_INSERT;
      offer(op, home[pick], TID_W'(pick), pick_key(op == sdlq_pkg::CMD_DELTA_INSERT));
    end else if (free_n > 0 &&
                 (free_n == THREADS || $urandom_range(0, 99) < insert_pct)) begin
      pick = $urandom_range(0, THREADS - 1);
      while (on_list[pick]) pick = $urandom_range(0, THREADS - 1);
      sel = allow_relink ? home[pick] : 1'($urandom);
      on_list[pick] = 1'b1;
      home[pick] = sel;
      if ($urandom_range(0, 99) < 85)
        op = sel ? sdlq_pkg::CMD_DELTA_INSERT : sdlq_pkg::CMD_PRIO_INSERT;
      else
        op = sel ? sdlq_pkg::CMD_PRIO_INSERT : sdlq_pkg::CMD_DELTA_INSERT;
      offer(op, sel, TID_W'(pick), pick_key(op == sdlq_pkg::CMD_DELTA_INSERT));
    end else begin
      if (ready_n == 0) sel = 1'b1;
      else if (sleep_n == 0) sel = 1'b0;
      else sel = 1'($urandom);
      offer(sdlq_pkg::CMD_DEQUEUE, sel, TID_W'($urandom), $urandom);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    request_ch.valid       = 1'b0;
    request_ch.cmd         = sdlq_pkg::CMD_PRIO_INSERT;
    request_ch.list_select = 1'b0;
    request_ch.thread_id   = '0;
    request_ch.key_value   = '0;
    long_hold  = 1'b0;
    rx_eager   = 1'b0;
    gap_max    = 2;
    burst_left = 1;
    for (int t = 0; t < THREADS; t++) begin
      on_list[t] = 1'b0;
      home[t]    = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Both lists empty, and the unused command.
    offer(sdlq_pkg::CMD_DEQUEUE, 1'b0, '0, '0);
    offer(sdlq_pkg::CMD_DEQUEUE, 1'b1, '1, '1);
    offer(CMD_RESERVED, 1'b1, TID_W'(10), 32'h5A5A_A5A5);

    // Ready list by priority: thread 0, the key extremes and a tie that must keep order.
    offer(sdlq_pkg::CMD_PRIO_INSERT, 1'b0, TID_W'(0), '0);
    offer(sdlq_pkg::CMD_PRIO_INSERT, 1'b0, TID_W'(15), '1);
    offer(sdlq_pkg::CMD_PRIO_INSERT, 1'b0, TID_W'(5), 32'd100);
    offer(sdlq_pkg::CMD_PRIO_INSERT, 1'b0, TID_W'(9), 32'd100);
    repeat (5) offer(sdlq_pkg::CMD_DEQUEUE, 1'b0, '0, '0);

    // Sleep list by delta: an insert ahead of a node, one at the tail, a zero delay
    // and the largest delay.
    offer(sdlq_pkg::CMD_DELTA_INSERT, 1'b1, TID_W'(3), 32'd50);
    offer(sdlq_pkg::CMD_DELTA_INSERT, 1'b1, TID_W'(7), 32'd20);
    offer(sdlq_pkg::CMD_DELTA_INSERT, 1'b1, TID_W'(12), 32'd80);
    offer(sdlq_pkg::CMD_DELTA_INSERT, 1'b1, TID_W'(1), '0);
    offer(sdlq_pkg::CMD_DELTA_INSERT, 1'b1, TID_W'(14), '1);
    repeat (6) offer(sdlq_pkg::CMD_DEQUEUE, 1'b1, '1, '0);

    gap_max = 4;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 500) begin
        long_hold = 1'b1;
      end else if (i == 800) begin
        request_ch.valid = 1'b0;
        wait (awaited_count == 0);
        @(negedge clk);
      end else if (i == 1000) begin
        gap_max  = 0;
        rx_eager = 1'b1;
      end else if (i == 1200) begin
        gap_max  = 8;
        rx_eager = 1'b0;
      end
      case ((i / 150) % 3)
        0:       random_item(75, i >= RANDOM_ITEMS - 60);
        1:       random_item(50, i >= RANDOM_ITEMS - 60);
        default: random_item(35, i >= RANDOM_ITEMS - 60);
      endcase
    end

    request_ch.valid = 1'b0;
    wait (awaited_count == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && awaited_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
